// ----- hdl/iou_pkg.sv -----
// Shared widths, reset values, queue record and back-end state type for the
// best-IoU box matcher. No dependencies; every other file imports this one.
package iou_pkg;

	localparam int COORD_BITS = 14;
	localparam int DIM_BITS   = COORD_BITS - 1;
	localparam int EXT_BITS   = COORD_BITS + 1;
	localparam int AREA_BITS  = 2 * DIM_BITS;
	localparam int RAREA_BITS = 2 * EXT_BITS;
	localparam int SUM_BITS   = RAREA_BITS + 1;
	localparam int UNI_BITS   = AREA_BITS + 3;
	localparam int PROD_BITS  = AREA_BITS + UNI_BITS;

	localparam int THR_BITS   = 9;
	localparam logic [THR_BITS-1:0] THR_RESET = 9'd154;
	localparam int THRP_BITS  = THR_BITS + UNI_BITS;
	localparam int FRAC_BITS  = 8;

	localparam int MAX_CANDS  = 256;
	localparam int CNT_BITS   = $clog2(MAX_CANDS + 1);
	localparam int IDX_BITS   = 8;

	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [AREA_BITS-1:0] inter;
		logic [UNI_BITS-1:0]  uni;
		logic                 ok;
		logic                 last;
	} cand_rec_t;

	typedef struct packed {
		logic [QCNT_BITS-1:0] level;
		logic                 empty;
	} q_status_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_UPD,
		B_THR,
		B_OUT
	} back_state_t;

endpackage

// ----- hdl/iou_front.sv -----
// Front end: accepts candidates, computes intersection and union areas in a
// two-stage pipeline and pushes one record per candidate. Depends on iou_pkg.
module iou_front import iou_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] cand_x,
	input  logic signed [COORD_BITS-1:0] cand_y,
	input  logic        [DIM_BITS-1:0]   cand_w,
	input  logic        [DIM_BITS-1:0]   cand_h,
	input  logic signed [COORD_BITS-1:0] ref_left,
	input  logic signed [COORD_BITS-1:0] ref_top,
	input  logic signed [COORD_BITS-1:0] ref_right,
	input  logic signed [COORD_BITS-1:0] ref_bottom,
	input  logic                         last_cand,
	input  q_status_t                    q_stat,
	output logic                         push,
	output cand_rec_t                    push_rec
);

	logic                       accept;
	logic signed [EXT_BITS-1:0] cx, cy, cx2, cy2, rl, rt, rr, rb;
	logic signed [EXT_BITS-1:0] xx1, yy1, xx2, yy2;
	logic signed [EXT_BITS:0]   dx, dy;
	logic        [DIM_BITS-1:0] w_c, h_c;
	logic        [QCNT_BITS:0]  occupancy;

	logic                        v_s1, v_s2;
	logic                        last_s1, last_s2;
	logic [DIM_BITS-1:0]         w_s1, h_s1, cw_s1, ch_s1;
	logic signed [EXT_BITS-1:0]  rw_s1, rh_s1;
	logic [AREA_BITS-1:0]        inter_s2, carea_s2;
	logic signed [RAREA_BITS-1:0] rarea_s2;
	logic signed [SUM_BITS-1:0]  uni_sum;

	// hold input while queue plus in-flight items could fill the queue
	assign occupancy = (QCNT_BITS+1)'(q_stat.level) + (QCNT_BITS+1)'(v_s1)
		+ (QCNT_BITS+1)'(v_s2);
	assign in_stall  = occupancy >= (QCNT_BITS+1)'(QDEPTH);
	assign accept    = in_valid && !in_stall;

	always_comb begin
		cx  = {cand_x[COORD_BITS-1], cand_x};
		cy  = {cand_y[COORD_BITS-1], cand_y};
		rl  = {ref_left[COORD_BITS-1], ref_left};
		rt  = {ref_top[COORD_BITS-1], ref_top};
		rr  = {ref_right[COORD_BITS-1], ref_right};
		rb  = {ref_bottom[COORD_BITS-1], ref_bottom};
		cx2 = cx + $signed({2'b00, cand_w});
		cy2 = cy + $signed({2'b00, cand_h});
		xx1 = (cx > rl) ? cx : rl;
		yy1 = (cy > rt) ? cy : rt;
		xx2 = (cx2 < rr) ? cx2 : rr;
		yy2 = (cy2 < rb) ? cy2 : rb;
		dx  = {xx2[EXT_BITS-1], xx2} - {xx1[EXT_BITS-1], xx1};
		dy  = {yy2[EXT_BITS-1], yy2} - {yy1[EXT_BITS-1], yy1};
		// overlap never exceeds the candidate size, so it fits DIM_BITS
		w_c = (dx > 0) ? dx[DIM_BITS-1:0] : '0;
		h_c = (dy > 0) ? dy[DIM_BITS-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_s1    <= w_c;
			h_s1    <= h_c;
			cw_s1   <= cand_w;
			ch_s1   <= cand_h;
			rw_s1   <= rr - rl;
			rh_s1   <= rb - rt;
			last_s1 <= last_cand;
		end
		if (v_s1) begin
			inter_s2 <= AREA_BITS'(w_s1) * AREA_BITS'(h_s1);
			carea_s2 <= AREA_BITS'(cw_s1) * AREA_BITS'(ch_s1);
			rarea_s2 <= RAREA_BITS'(rw_s1) * RAREA_BITS'(rh_s1);
			last_s2  <= last_s1;
		end
	end

	assign uni_sum = $signed({(SUM_BITS-AREA_BITS)'(0), carea_s2})
		+ $signed({rarea_s2[RAREA_BITS-1], rarea_s2})
		- $signed({(SUM_BITS-AREA_BITS)'(0), inter_s2});

	assign push = v_s2;
	always_comb begin
		push_rec.inter = inter_s2;
		push_rec.uni   = uni_sum[UNI_BITS-1:0];
		push_rec.ok    = !uni_sum[SUM_BITS-1] && (uni_sum != '0) && (inter_s2 != '0);
		push_rec.last  = last_s2;
	end

endmodule

// ----- hdl/iou_queue.sv -----
// Small FIFO of candidate records between the front and back ends.
// Depends on iou_pkg.
module iou_queue import iou_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cand_rec_t push_rec,
	input  logic      pop,
	output cand_rec_t pop_rec,
	output q_status_t stat
);

	cand_rec_t            entry_q [QDEPTH];
	logic [QPTR_BITS-1:0] head_q, tail_q;
	logic [QCNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) tail_q <= tail_q + 1'b1;
			if (pop)  head_q <= head_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[tail_q] <= push_rec;
	end

	assign pop_rec    = entry_q[head_q];
	assign stat.level = count_q;
	assign stat.empty = (count_q == '0);

endmodule

// ----- hdl/iou_back.sv -----
// Back end: serial compare-and-update of the best IoU pair, threshold test
// at end of run and the result register. Depends on iou_pkg.
module iou_back import iou_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [THR_BITS-1:0] thr,
	input  q_status_t           q_stat,
	input  cand_rec_t           pop_rec,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                found,
	output logic [IDX_BITS-1:0] best_index
);

	back_state_t state_q, state_d;

	cand_rec_t             cur_q;
	logic [PROD_BITS-1:0]  prod_new_q, prod_best_q;
	logic [THRP_BITS-1:0]  thr_prod_q;
	logic [AREA_BITS-1:0]  best_inter_q;
	logic [UNI_BITS-1:0]   best_union_q;
	logic [IDX_BITS-1:0]   best_pos_q;
	logic                  have_best_q;
	logic [CNT_BITS-1:0]   cand_count_q;
	logic                  out_valid_q, found_q;
	logic [IDX_BITS-1:0]   best_index_q;

	logic counting, take, load_out, hit;

	assign counting = cand_count_q < CNT_BITS'(MAX_CANDS);
	assign hit = have_best_q &&
		({(THRP_BITS-AREA_BITS-FRAC_BITS)'(0), best_inter_q, FRAC_BITS'(0)} >= thr_prod_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_stat.empty) state_d = B_MUL;
			B_MUL:  state_d = B_UPD;
			B_UPD:  state_d = cur_q.last ? B_THR : B_IDLE;
			B_THR:  state_d = B_OUT;
			B_OUT:  if (!out_valid_q || !out_stall) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		take     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE: pop = !q_stat.empty;
			B_UPD:  take = cur_q.ok && counting && (!have_best_q || prod_new_q > prod_best_q);
			B_OUT:  load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			have_best_q  <= 1'b0;
			cand_count_q <= '0;
			best_inter_q <= '0;
			best_union_q <= '0;
			best_pos_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				best_inter_q <= cur_q.inter;
				best_union_q <= cur_q.uni;
				best_pos_q   <= cand_count_q[IDX_BITS-1:0];
				have_best_q  <= 1'b1;
			end
			if (state_q == B_UPD && counting) cand_count_q <= cand_count_q + 1'b1;
			if (load_out) begin
				// clear the run once its result is registered
				have_best_q  <= 1'b0;
				cand_count_q <= '0;
				best_inter_q <= '0;
				best_union_q <= '0;
				best_pos_q   <= '0;
			end
			if (load_out)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_rec;
		if (state_q == B_MUL) begin
			prod_new_q  <= PROD_BITS'(cur_q.inter) * PROD_BITS'(best_union_q);
			prod_best_q <= PROD_BITS'(best_inter_q) * PROD_BITS'(cur_q.uni);
		end
		if (state_q == B_THR) thr_prod_q <= THRP_BITS'(thr) * THRP_BITS'(best_union_q);
		if (load_out) begin
			found_q      <= hit;
			best_index_q <= hit ? best_pos_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign best_index = best_index_q;

endmodule

// ----- hdl/iou_best_box_match_top.sv -----
// Top level of the best-IoU box matcher: threshold register, front end,
// record queue and back end. Depends on iou_pkg, iou_front, iou_queue, iou_back.

// Streams a run of candidate boxes (x, y, w, h) against one reference box
// (left, top, right, bottom) and, on the candidate marked last_cand, returns
// one transaction: found = 1 when the best IoU of the run is at least
// threshold/256, with best_index the 0-based position of that candidate
// (first one wins ties), else found = 0 and best_index = 0. Candidates with
// zero IoU never count, and candidates at position 256 or beyond are ignored
// apart from their last mark. The front end computes areas in a two-stage
// pipeline and can take one transaction per cycle until the four-entry queue,
// counting the candidates still in the two pipeline stages, is full. The back
// end compares by cross-multiplication through its pop, multiply and
// update steps and finishes each candidate before popping the next; the
// last candidate of a run adds the threshold-product and result-register
// steps. Results sit in an output register, so the next run keeps flowing
// while a result waits, until its own result is due.
// Write the match threshold (reset 154) only while no run is in progress.
module iou_best_box_match_top import iou_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [THR_BITS-1:0]          cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] cand_x,
	input  logic signed [COORD_BITS-1:0] cand_y,
	input  logic        [DIM_BITS-1:0]   cand_w,
	input  logic        [DIM_BITS-1:0]   cand_h,
	input  logic signed [COORD_BITS-1:0] ref_left,
	input  logic signed [COORD_BITS-1:0] ref_top,
	input  logic signed [COORD_BITS-1:0] ref_right,
	input  logic signed [COORD_BITS-1:0] ref_bottom,
	input  logic                         last_cand,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [IDX_BITS-1:0]          best_index
);

	logic [THR_BITS-1:0] thr_q;
	logic                push, pop;
	cand_rec_t           push_rec, pop_rec;
	q_status_t           q_stat;

	// hold the threshold; reset to 0.6 in 1/256 units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// classify: geometry and areas, one record per candidate
	iou_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cand_x     (cand_x),
		.cand_y     (cand_y),
		.cand_w     (cand_w),
		.cand_h     (cand_h),
		.ref_left   (ref_left),
		.ref_top    (ref_top),
		.ref_right  (ref_right),
		.ref_bottom (ref_bottom),
		.last_cand  (last_cand),
		.q_stat     (q_stat),
		.push       (push),
		.push_rec   (push_rec)
	);

	// decouple the pipelined front from the serial back
	iou_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.stat     (q_stat)
	);

	// advance the best pair and emit the result at end of run
	iou_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.q_stat     (q_stat),
		.pop_rec    (pop_rec),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.best_index (best_index)
	);

endmodule
